// ----- design/pal_pkg.sv -----
// shared constants, codes and types for the positional array list
package pal_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int DATA_W = 64;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(DEPTH);

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              take;
    logic              ins;
    logic              del;
    logic              find;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- design/pal_if.sv -----
// request and response channel interfaces of the positional array list
interface pal_req_if
  import pal_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink (input valid, mode, position, value, output ready);
endinterface

interface pal_rsp_if
  import pal_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] read_value;
  logic [IDX_W-1:0]         found_index;
  logic [CNT_W-1:0]         length;
  logic                     is_full;
  logic                     is_empty;

  modport source (output valid, status, read_value, found_index, length, is_full, is_empty,
                  input ready);
  modport sink (input valid, status, read_value, found_index, length, is_full, is_empty,
                output ready);
endinterface

// ----- design/positional_array_list.sv -----
// top level of the positional array list: command decode, cell chain, response register
// the flags of an item are registered at accept, its result once the response register is free
// an item is taken only once the last is loaded; the chain updates at accept, flags resolve next
// a result waiting on the receiver holds the resolved item, which holds off the next item
// reset (synchronous, rst high) empties the list and clears valid; slot contents stay undefined
// no clearing pass is needed after reset
module positional_array_list
  import pal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pal_req_if.sink    req,
  pal_rsp_if.source  rsp
);

  logic              accept;
  logic              pend;
  logic              load;
  logic [MODE_W-1:0] mode_q;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] status_next;
  logic              do_ins;
  logic              do_del;
  cell_cmd_t         cmd;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  sel;
  logic              any_match;
  logic [IDX_W-1:0]  first_index;
  logic [DATA_W-1:0] sel_data;

  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [DATA_W-1:0]        out_read;
  logic [IDX_W-1:0]         out_index;
  logic [CNT_W-1:0]         out_len;

  assign req.ready = !pend && !rst;
  assign accept    = req.valid && req.ready;
  assign load      = pend && (!out_valid || rsp.ready);

  // decode the operation against the current length
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    case (req.mode)
      MODE_INSERT: begin
        if (CNT_W'(req.position) > count) begin
          status_next = ST_BAD_POS;
        end else if (count >= COUNT_FULL) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (CNT_W'(req.position) >= count) begin
          status_next = ST_BAD_POS;
        end else begin
          do_del     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      MODE_FIND: begin
        status_next = ST_NOT_FOUND;
      end
      MODE_GET: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (CNT_W'(req.position) >= count) begin
          status_next = ST_BAD_POS;
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  // command broadcast to the chain
  assign cmd.take  = accept;
  assign cmd.ins   = accept && do_ins;
  assign cmd.del   = accept && do_del;
  assign cmd.find  = accept && (req.mode == MODE_FIND);
  assign cmd.pos   = req.position;
  assign cmd.count = count;
  assign cmd.value = req.value;

  // the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = req.value;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end
    pal_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .match      (match[i]),
      .sel        (sel[i])
    );
  end

  pal_resolve u_resolve (
    .match       (match),
    .sel         (sel),
    .cell_data   (cell_data),
    .any_match   (any_match),
    .first_index (first_index),
    .sel_data    (sel_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend  <= 1'b1;
        count <= count_next;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item held between accept and resolve
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= req.mode;
      status_q <= status_next;
    end
  end

  // response register, length captured with the result
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= status_q;
      out_read   <= '0;
      out_index  <= '0;
      out_len    <= count;
      if (mode_q == MODE_FIND && any_match) begin
        out_status <= ST_OK;
        out_index  <= first_index;
      end
      if (mode_q == MODE_GET && status_q == ST_OK) begin
        out_read <= sel_data;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_read;
  assign rsp.found_index = out_index;
  assign rsp.length      = out_len;
  assign rsp.is_full     = (out_len == COUNT_FULL);
  assign rsp.is_empty    = (out_len == '0);

endmodule

// ----- design/pal_cell.sv -----
// one list slot: holds an element, shifts with its neighbors, flags match and select
module pal_cell
  import pal_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic              match,
  output logic              sel
);

  logic [POS_W-1:0]  my_pos;
  logic              occupied;
  logic [DATA_W-1:0] data_next;

  assign my_pos   = POS_W'(idx);
  assign occupied = CNT_W'(idx) < cmd.count;

  // shift up on insert, down on delete
  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (my_pos == cmd.pos) begin
        data_next = cmd.value;
      end else if (my_pos > cmd.pos) begin
        data_next = left_data;
      end
    end else if (cmd.del) begin
      if (my_pos >= cmd.pos) begin
        data_next = right_data;
      end
    end
  end

  // flags are taken with the item and held until the next one
  always_ff @(posedge clk) begin
    data <= data_next;
    if (cmd.take) begin
      match <= cmd.find && occupied && (data == cmd.value);
      sel   <= (my_pos == cmd.pos);
    end
  end

endmodule

// ----- design/pal_resolve.sv -----
// first-match encoder and selected-slot read over the cell flags
module pal_resolve
  import pal_pkg::*;
(
  input  logic [DEPTH-1:0]  match,
  input  logic [DEPTH-1:0]  sel,
  input  logic [DATA_W-1:0] cell_data [DEPTH],
  output logic              any_match,
  output logic [IDX_W-1:0]  first_index,
  output logic [DATA_W-1:0] sel_data
);

  logic [DEPTH-1:0] lowest;

  // isolate the lowest set match bit
  assign lowest    = match & (~match + DEPTH'(1));
  assign any_match = |match;

  // one-hot to binary
  always_comb begin
    first_index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) first_index = first_index | IDX_W'(i);
    end
  end

  // and-or read of the selected slot
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_data = sel_data | (cell_data[i] & {DATA_W{sel[i]}});
    end
  end

endmodule

// ----- design/pal_checker.sv -----
// port-level checks on the positional array list, bound to the top level
module pal_checker
  import pal_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STAT_W-1:0] status,
  input logic [DATA_W-1:0] read_value,
  input logic [IDX_W-1:0]  found_index,
  input logic [CNT_W-1:0]  length,
  input logic              is_full,
  input logic              is_empty
);

  // flags agree with the reported length
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (length == '0)) && (is_full == (length == COUNT_FULL)))
    else $error("length flags disagree with length");

  // a full status only when the list is full
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> is_full)
    else $error("full status on a list that is not full");

  // read data and index only with an ok status
  a_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> read_value == '0 && found_index == '0)
    else $error("payload set on a failed item");

  // length never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> length <= COUNT_FULL)
    else $error("length beyond capacity");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(read_value))
    else $error("stalled result changed");

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .read_value  (rsp.read_value),
  .found_index (rsp.found_index),
  .length      (rsp.length),
  .is_full     (rsp.is_full),
  .is_empty    (rsp.is_empty)
);

// ----- bench/positional_array_list_tb.sv -----
// testbench for the positional array list: random and directed list operations checked by a predictor
module positional_array_list_tb
  import pal_pkg::*;
();

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         length;
    logic                     is_full;
    logic                     is_empty;
  } list_result_t;

  localparam int RANDOM_OPS = 2000;
  localparam int LIMIT_TIME = 4_000_000;

  logic clk;
  logic rst;

  pal_req_if req();
  pal_rsp_if rsp();

  positional_array_list dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // predicted list contents
  logic signed [DATA_W-1:0] list_slots [DEPTH];
  int                       list_len;

  list_op_t     pending_ops [$];
  list_result_t expected_results [$];

  // generator-side view of the list length, used only to shape stimulus
  int shadow_len;
  logic signed [DATA_W-1:0] value_pool [8];

  int   errors;
  logic req_taken;
  int   gap_left;
  int   burst_left;
  logic hold_rsp;
  int   stall_style;
  int   style_left;
  int   rsp_cycle;
  list_op_t     next_op;
  list_result_t want;
  list_result_t got;

  always #5 clk = ~clk;

  // apply one operation to the predicted list and return its result
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t r;
    int           p;
    int           i;
    logic         hit;
    r = '0;
    r.status = ST_OK;
    p = int'(op.pos);
    hit = 1'b0;
    case (op.mode)
      MODE_INSERT: begin
        if (p > list_len) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_slots[i] = list_slots[i-1];
          list_slots[p] = op.value;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_slots[i] = list_slots[i+1];
          list_len--;
        end
      end
      MODE_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (!hit && list_slots[i] == op.value) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = IDX_W'(i);
          end
        end
      end
      default: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.read_value = list_slots[p];
        end
      end
    endcase
    r.length   = CNT_W'(list_len);
    r.is_full  = (list_len == DEPTH);
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  // queue one operation and track the length it leaves behind
  task automatic queue_op(logic [MODE_W-1:0] mode, int pos, logic signed [DATA_W-1:0] value);
    list_op_t op;
    op.mode  = mode;
    op.pos   = POS_W'(pos);
    op.value = value;
    pending_ops.push_back(op);
    if (mode == MODE_INSERT && pos <= shadow_len && shadow_len < DEPTH) shadow_len++;
    else if (mode == MODE_DELETE && pos < shadow_len) shadow_len--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // record accepted items and run the predictor
  always @(posedge clk) begin
    req_taken = !rst && req.valid && req.ready;
    if (req_taken) begin
      next_op.mode  = req.mode;
      next_op.pos   = req.position;
      next_op.value = req.value;
      expected_results.push_back(apply_list_op(next_op));
    end
  end

  // request driver: bursts of items separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (gap_left > 0) begin
        req.valid <= 1'b0;
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        req.valid    <= 1'b1;
        req.mode     <= next_op.mode;
        req.position <= next_op.pos;
        req.value    <= next_op.value;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response ready: the stall style is redrawn at random whenever its run ends
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp_cycle++;
      if (style_left <= 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(100, 300);
      end
      style_left--;
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
      end else begin
        case (stall_style)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp.ready <= $urandom_range(0, 1);
          default: rsp.ready <= (rsp_cycle % 5 != 0);
        endcase
      end
    end
  end

  // long receiver hold-offs so the block backs up into its input
  initial begin
    hold_rsp = 1'b0;
    @(negedge rst);
    repeat (600) @(posedge clk);
    hold_rsp = 1'b1;
    repeat (300) @(posedge clk);
    hold_rsp = 1'b0;
    repeat (2500) @(posedge clk);
    hold_rsp = 1'b1;
    repeat (150) @(posedge clk);
    hold_rsp = 1'b0;
  end

  // result monitor: compare each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      got.status      = rsp.status;
      got.read_value  = rsp.read_value;
      got.found_index = rsp.found_index;
      got.length      = rsp.length;
      got.is_full     = rsp.is_full;
      got.is_empty    = rsp.is_empty;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status=%0d len=%0d", got.status, got.length));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.read_value !== want.read_value ||
            got.found_index !== want.found_index || got.length !== want.length ||
            got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
          note_failure($sformatf(
            "mismatch: exp st=%0d rd=%0h idx=%0d len=%0d f=%0b e=%0b, got st=%0d rd=%0h %s",
            want.status, want.read_value, want.found_index, want.length, want.is_full,
            want.is_empty, got.status, got.read_value,
            $sformatf("idx=%0d len=%0d f=%0b e=%0b", got.found_index, got.length,
                      got.is_full, got.is_empty)));
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    int phase_kind;
    int phase_left;
    int roll;
    int pos;
    logic [MODE_W-1:0] mode;

    clk = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = MODE_INSERT;
    req.position = '0;
    req.value = '0;
    rsp.ready = 1'b0;
    errors = 0;
    req_taken = 1'b0;
    gap_left = 0;
    burst_left = 8;
    stall_style = 0;
    style_left = 0;
    rsp_cycle = 0;
    list_len = 0;
    shadow_len = 0;
    phase_kind = 0;
    phase_left = 0;

    value_pool[0] = {1'b0, {(DATA_W-1){1'b1}}};
    value_pool[1] = {1'b1, {(DATA_W-1){1'b0}}};
    value_pool[2] = '0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (n = 5; n < 8; n++) value_pool[n] = {$urandom, $urandom};

    // directed: empty list cases, extremes, ends and middles
    queue_op(MODE_GET,    0,   0);
    queue_op(MODE_DELETE, 0,   0);
    queue_op(MODE_FIND,   0,   0);
    queue_op(MODE_INSERT, 1,   5);
    queue_op(MODE_INSERT, 0,   value_pool[0]);
    queue_op(MODE_INSERT, 1,   value_pool[1]);
    queue_op(MODE_INSERT, 0,   -1);
    queue_op(MODE_INSERT, 1,   0);
    queue_op(MODE_INSERT, 4,   value_pool[0]);
    queue_op(MODE_FIND,   0,   value_pool[0]);
    queue_op(MODE_FIND,   0,   12345);
    queue_op(MODE_GET,    0,   0);
    queue_op(MODE_GET,    4,   0);
    queue_op(MODE_GET,    5,   0);
    queue_op(MODE_GET,    127, 0);
    queue_op(MODE_DELETE, 127, 0);
    queue_op(MODE_DELETE, 5,   0);
    queue_op(MODE_DELETE, 2,   0);
    queue_op(MODE_DELETE, 3,   0);
    queue_op(MODE_DELETE, 0,   0);
    queue_op(MODE_INSERT, 127, 7);
    queue_op(MODE_FIND,   0,   value_pool[1]);

    // random: grow, shrink and mixed phases with some noise
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        phase_kind = $urandom_range(0, 2);
        phase_left = $urandom_range(60, 200);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        queue_op(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 127), {$urandom, $urandom});
      end else begin
        if (phase_kind == 0)
          mode = roll < 65 ? MODE_INSERT : roll < 75 ? MODE_DELETE :
                 roll < 88 ? MODE_FIND : MODE_GET;
        else if (phase_kind == 1)
          mode = roll < 15 ? MODE_INSERT : roll < 65 ? MODE_DELETE :
                 roll < 82 ? MODE_FIND : MODE_GET;
        else
          mode = MODE_W'(roll % 4);
        if ($urandom_range(0, 19) == 0)
          pos = shadow_len + $urandom_range(0, 2);
        else if (mode == MODE_INSERT)
          pos = $urandom_range(0, shadow_len);
        else
          pos = (shadow_len > 0) ? $urandom_range(0, shadow_len - 1) : 0;
        queue_op(mode, pos, pick_value());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // drain: all items sent, all results back, then a short quiet window
    while (pending_ops.size() != 0 || req.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS positional_array_list");
    end else begin
      $display("FAIL positional_array_list");
    end
    $finish;
  end

  // run limit
  initial begin
    #LIMIT_TIME;
    $display("FAIL positional_array_list");
    $finish;
  end

endmodule
